// ----- sv/kfhp_pkg.sv -----
`default_nettype none

package kfhp_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_FIELD_W = 8;
    localparam int PART_W      = 16;
    localparam int HASH_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_CNT_W   = 5;

    localparam logic [HASH_W-1:0] HASH_INIT    = 32'd1;
    localparam logic [CFG_DATA_W-1:0] SEP_MASK0_RST = 64'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIELDS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_FIELDS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_MASK_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_MASK_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_MASK_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_MASK_3  = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              line_end;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              in_key;
        logic              is_last;
        logic [PART_W-1:0] partition;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_DIV
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic item_last;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/kfhp_datapath.sv -----
`default_nettype none

module kfhp_datapath #(
    parameter int FIELD_COUNT_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [kfhp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kfhp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire kfhp_pkg::in_item_t                  in_item,
    input  wire kfhp_pkg::dp_cmd_t                   cmd,
    output kfhp_pkg::dp_status_t                     status,
    output kfhp_pkg::out_item_t                      out_item
);
    import kfhp_pkg::*;

    localparam int LIM_W = (FIELD_COUNT_BITS > CFG_FIELD_W) ? FIELD_COUNT_BITS : CFG_FIELD_W;
    localparam logic [LIM_W-1:0] CNT_MAX = LIM_W'((1 << FIELD_COUNT_BITS) - 1);
    localparam logic [FIELD_COUNT_BITS-1:0] CNT_ONE = FIELD_COUNT_BITS'(1);

    // configuration
    logic [CFG_FIELD_W-1:0]  key_fc_reg;
    logic [CFG_FIELD_W-1:0]  part_fc_reg;
    logic [PART_W-1:0]       part_cnt_reg;
    logic [4*CFG_DATA_W-1:0] sep_mask_reg;

    // per-line state
    logic [HASH_W-1:0]           hash_reg, hash_next;
    logic [FIELD_COUNT_BITS-1:0] key_seen_reg, key_seen_next;
    logic [FIELD_COUNT_BITS-1:0] part_seen_reg, part_seen_next;
    logic                        nonempty_reg, nonempty_next;

    // remainder unit
    logic [HASH_W-2:0]    dvd_reg;
    logic [PART_W-1:0]    div_reg;
    logic [PART_W:0]      rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 part_ok_reg;
    logic [PART_W:0]      rem_shift;
    logic [PART_W:0]      rem_sub;

    out_item_t out_reg;

    logic [FIELD_COUNT_BITS-1:0] key_lim, part_lim;
    logic                        sep, key_member, part_member;
    logic [HASH_W-1:0]           hash_upd;

    function automatic logic [FIELD_COUNT_BITS-1:0] eff_limit(input logic [CFG_FIELD_W-1:0] r);
        logic [LIM_W-1:0] v;
        v = LIM_W'(r);
        if (v == '0)
            v = LIM_W'(1);
        else if (v > CNT_MAX)
            v = CNT_MAX;
        return v[FIELD_COUNT_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_fc_reg   <= CFG_FIELD_W'(1);
            part_fc_reg  <= CFG_FIELD_W'(1);
            part_cnt_reg <= PART_W'(1);
            sep_mask_reg <= {{(3*CFG_DATA_W){1'b0}}, SEP_MASK0_RST};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_FIELDS:  key_fc_reg   <= cfg_data[CFG_FIELD_W-1:0];
                CFG_PART_FIELDS: part_fc_reg  <= cfg_data[CFG_FIELD_W-1:0];
                CFG_PART_COUNT:  part_cnt_reg <= cfg_data[PART_W-1:0];
                CFG_SEP_MASK_0:  sep_mask_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_SEP_MASK_1:  sep_mask_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_SEP_MASK_2:  sep_mask_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_SEP_MASK_3:  sep_mask_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        key_lim  = eff_limit(key_fc_reg);
        part_lim = eff_limit(part_fc_reg);
        sep      = sep_mask_reg[in_item.byte_in];

        key_member    = (key_seen_reg < key_lim) &&
                        (!sep || !((key_seen_reg + CNT_ONE == key_lim) || in_item.line_end));
        key_seen_next = key_seen_reg;
        if ((key_seen_reg < key_lim) && sep)
            key_seen_next = key_seen_reg + CNT_ONE;

        part_member    = (part_seen_reg < part_lim) &&
                         (!sep || !((part_seen_reg + CNT_ONE == part_lim) || in_item.line_end));
        part_seen_next = part_seen_reg;
        if ((part_seen_reg < part_lim) && sep)
            part_seen_next = part_seen_reg + CNT_ONE;

        // h*31 + signed byte
        hash_upd  = (hash_reg << 5) - hash_reg + {{(HASH_W-BYTE_W){in_item.byte_in[BYTE_W-1]}},
                                                  in_item.byte_in};
        hash_next     = part_member ? hash_upd : hash_reg;
        nonempty_next = nonempty_reg | part_member;

        rem_shift = {rem_reg[PART_W-1:0], dvd_reg[HASH_W-2]};
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_INIT;
            key_seen_reg  <= '0;
            part_seen_reg <= '0;
            nonempty_reg  <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (in_item.line_end)
            begin
                hash_reg      <= HASH_INIT;
                key_seen_reg  <= '0;
                part_seen_reg <= '0;
                nonempty_reg  <= 1'b0;
            end
            else
            begin
                hash_reg      <= hash_next;
                key_seen_reg  <= key_seen_next;
                part_seen_reg <= part_seen_next;
                nonempty_reg  <= nonempty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            out_reg.byte_out  <= in_item.byte_in;
            out_reg.in_key    <= key_member;
            out_reg.is_last   <= in_item.line_end;
            out_reg.partition <= '0;
            dvd_reg           <= hash_next[HASH_W-2:0];
            div_reg           <= part_cnt_reg;
            rem_reg           <= '0;
            cnt_reg           <= '0;
            part_ok_reg       <= nonempty_next && (part_cnt_reg != '0);
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[HASH_W-3:0], 1'b0};
            rem_reg <= (rem_shift >= {1'b0, div_reg}) ? rem_sub : rem_shift;
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        else if (cmd.finish)
        begin
            out_reg.partition <= part_ok_reg ? rem_reg[PART_W-1:0] : '0;
        end
    end

    always_comb
    begin
        status.item_last = in_item.line_end;
        status.div_done  = (cnt_reg == DIV_CNT_W'(DIV_STEPS));
        out_item         = out_reg;
    end

endmodule

`default_nettype wire

// ----- sv/kfhp_ctrl.sv -----
`default_nettype none

module kfhp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire kfhp_pkg::dp_status_t status,
    output kfhp_pkg::dp_cmd_t         cmd
);
    import kfhp_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        accept         = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_stall = out_valid_reg & out_stall;
                accept   = in_valid & ~in_stall;
                cmd.take = accept;
                if (accept)
                begin
                    if (status.item_last)
                        state_next = ST_DIV;
                    else
                        out_valid_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        out_valid = out_valid_reg;
    end

    a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> in_stall)
        else $error("input taken during remainder");

    a_div_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !out_valid_reg)
        else $error("output valid during remainder");

    a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.item_last) |=> (state_reg == ST_DIV))
        else $error("last item did not start remainder");

    a_finish_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished line without result");

endmodule

`default_nettype wire

// ----- sv/key_field_hash_partitioner.sv -----
// A byte without line_end gives its item in the cycle after it is accepted.
// A byte with line_end first loads a one-bit-per-cycle remainder unit, which runs 31
// steps and then writes the partition; its item appears after that, input stalled meanwhile.
// Throughput: one byte per cycle inside a line while the output is not stalled.
// Reset (rst_n low, asynchronous): registers to their defaults, line state cleared,
// output empty.
`default_nettype none

module key_field_hash_partitioner #(
    parameter int FIELD_COUNT_BITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire kfhp_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output kfhp_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_we,
    input  wire logic [kfhp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kfhp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kfhp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    kfhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kfhp_datapath #(
        .FIELD_COUNT_BITS (FIELD_COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
